// ===== rtl/core/quaternion_vector_rotate_unit_assert.svh =====
// Assertion macros for the quaternion vector rotation unit.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QVR_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("quaternion rotate unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QVR_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("quaternion rotate unit: next-cycle check failed");

`endif

// ===== rtl/core/qvr_pkg.sv =====
// Shared constants and types of the quaternion vector rotation unit.
package qvr_pkg;

	localparam int DATA_W       = 32;
	localparam int MAG_W        = 31;
	localparam int NORM_W       = 31;
	localparam int SQ2_W        = 63;
	localparam int ROOT_W       = 32;
	localparam int NUM_W        = 61;
	localparam int QUO_W        = 31;
	localparam int T_W          = 35;
	localparam int RES_W        = 34;
	localparam int UNIT_FRAC    = 30;
	localparam int ISQRT_STAGES = 32;
	localparam int DIV_STAGES   = 31;

	localparam logic [MAG_W-1:0] MIN_MAG_RESET = 31'd1;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [3:0][NORM_W-1:0] norm4_t;

	typedef struct packed {
		logic            reject;
		logic [3:0]      qneg;
		word_t [2:0]     vec;
	} side_t;

endpackage

// ===== rtl/core/qvr_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qvr_isqrt (
	input  logic                         clk,
	input  logic                         adv,
	input  logic [qvr_pkg::SQ2_W-1:0]    radicand,
	output logic [qvr_pkg::ROOT_W-1:0]   root
);
	import qvr_pkg::*;

	localparam int RW = SQ2_W + 1;

	logic [RW-1:0] n_s    [ISQRT_STAGES];
	logic [RW-1:0] root_s [ISQRT_STAGES];

	for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_stage
		logic [RW-1:0] n_in;
		logic [RW-1:0] r_in;
		logic [RW-1:0] bitv;
		logic [RW-1:0] trial;

		if (k == 0) begin : g_first
			assign n_in = {1'b0, radicand};
			assign r_in = '0;
		end else begin : g_next
			assign n_in = n_s[k-1];
			assign r_in = root_s[k-1];
		end

		assign bitv  = RW'(1) << (2 * (ISQRT_STAGES - 1 - k));
		assign trial = r_in + bitv;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (n_in >= trial) begin
					n_s[k]    <= n_in - trial;
					root_s[k] <= (r_in >> 1) + bitv;
				end else begin
					n_s[k]    <= n_in;
					root_s[k] <= r_in >> 1;
				end
			end
		end
	end

	assign root = root_s[ISQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/qvr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module qvr_div (
	input  logic                        clk,
	input  logic                        adv,
	input  logic [qvr_pkg::NUM_W-1:0]   num,
	input  logic [qvr_pkg::ROOT_W-1:0]  den,
	output logic [qvr_pkg::QUO_W-1:0]   quo
);
	import qvr_pkg::*;

	localparam int CW = NUM_W + 2;

	logic [NUM_W-1:0]  rem_s [DIV_STAGES];
	logic [ROOT_W-1:0] den_s [DIV_STAGES];
	logic [QUO_W-1:0]  quo_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [NUM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] den_in;
		logic [QUO_W-1:0]  quo_in;
		logic [CW-1:0]     dsh;
		logic [CW-1:0]     rem_ext;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign dsh     = CW'(den_in) << (DIV_STAGES - 1 - k);
		assign rem_ext = CW'(rem_in);

		always_ff @(posedge clk) begin
			if (adv) begin
				den_s[k] <= den_in;
				if (rem_ext >= dsh) begin
					rem_s[k] <= NUM_W'(rem_ext - dsh);
					quo_s[k] <= quo_in | (QUO_W'(1) << (DIV_STAGES - 1 - k));
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

// ===== rtl/core/quaternion_vector_rotate_unit.sv =====
// Top level of the quaternion vector rotation unit.
//
// Rotates a vector by a quaternion that need not be of unit length. The unit
// takes one transfer per clock while the output side keeps up and returns one
// result transfer per input, in order. The pipeline consists of the
// 32-stage square-root pipeline and the 31-stage divider used for
// normalization, plus 17 stages of squaring, magnitude test, scaling,
// dividend setup, the two cross products, rounding and the output
// register. The whole pipeline advances together:
// it moves whenever the output register is empty or being taken, so a stalled
// output freezes every stage and nothing is lost or repeated. The magnitude
// test compares the sum of squares of the raw quaternion against the square
// of min_magnitude plus one; too small a quaternion gives zero outputs with
// invalid set. An output that leaves the 32-bit range saturates and also sets
// invalid. min_magnitude is written through the cfg channel, which is always
// ready, and should only be written while the unit is empty.
`include "quaternion_vector_rotate_unit_assert.svh"

module quaternion_vector_rotate_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qvr_pkg::MAG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [qvr_pkg::DATA_W-1:0] quat_w,
	input  logic signed [qvr_pkg::DATA_W-1:0] quat_x,
	input  logic signed [qvr_pkg::DATA_W-1:0] quat_y,
	input  logic signed [qvr_pkg::DATA_W-1:0] quat_z,
	input  logic signed [qvr_pkg::DATA_W-1:0] vec_x,
	input  logic signed [qvr_pkg::DATA_W-1:0] vec_y,
	input  logic signed [qvr_pkg::DATA_W-1:0] vec_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [qvr_pkg::DATA_W-1:0] out_x,
	output logic signed [qvr_pkg::DATA_W-1:0] out_y,
	output logic signed [qvr_pkg::DATA_W-1:0] out_z,
	output logic                          invalid
);
	import qvr_pkg::*;

	localparam int LAT = ISQRT_STAGES + 1 + DIV_STAGES;
	localparam logic [63:0] T_RND   = 64'd1 << (UNIT_FRAC - 2);
	localparam logic [63:0] R_RND   = 64'd1 << (UNIT_FRAC - 1);
	localparam logic [DATA_W-1:0] HALF_RANGE = DATA_W'(1) << UNIT_FRAC;
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic adv;
	logic [MAG_W-1:0] min_mag_q;

	// Every stage moves on the same enable; the output register is the last stage.
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= MIN_MAG_RESET;
		end else if (cfg_valid) begin
			min_mag_q <= cfg_data;
		end
	end

	// Stage 1: split the quaternion into magnitudes and signs.
	word_t qin [4];
	assign qin[0] = quat_w;
	assign qin[1] = quat_x;
	assign qin[2] = quat_y;
	assign qin[3] = quat_z;

	logic [DATA_W-1:0] qm_s1 [4];
	logic [3:0]        qneg_s1;
	word_t [2:0]       vec_s1;
	logic              vld_s1;

	// Stages 2 to 5: raw squares, their sum, the largest magnitude, the test.
	logic [63:0]       sq_s2 [4];
	logic [63:0]       lim_s2, lim_s3, lim_s4;
	logic [DATA_W-1:0] qm_s2 [4], qm_s3 [4], qm_s4 [4], qm_s5 [4];
	logic [3:0]        qneg_s2, qneg_s3, qneg_s4, qneg_s5, qneg_s6, qneg_s7, qneg_s8, qneg_s9;
	word_t [2:0]       vec_s2, vec_s3, vec_s4, vec_s5, vec_s6, vec_s7, vec_s8, vec_s9;
	logic              vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [64:0]       sum01_s3, sum23_s3;
	logic [DATA_W-1:0] max01_s3, max23_s3, amax_s4;
	logic [65:0]       ssum_s4;
	logic              rej_s5, rej_s6, rej_s7, rej_s8, rej_s9;
	logic              shr_s5;
	logic [4:0]        shl_s5, shl_c;

	// Stages 6 to 9: scaled magnitudes and the sum of their squares.
	norm4_t            qn_s6, qn_s7, qn_s8, qn_s9;
	logic [61:0]       sq2_s7 [4];
	logic [62:0]       p01_s8, p23_s8, s2_s9;

	logic [DATA_W-1:0] mm1;
	assign mm1 = DATA_W'(min_mag_q) + DATA_W'(1);

	// Left shift that brings the largest magnitude to at least 2^29.
	always_comb begin
		shl_c = '0;
		for (int b = 0; b < UNIT_FRAC - 1; b++) begin
			if (amax_s4[b]) begin
				shl_c = 5'(UNIT_FRAC - 1 - b);
			end
		end
		if (|amax_s4[DATA_W-1:UNIT_FRAC-1]) begin
			shl_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				qm_s1[i] <= qin[i][DATA_W-1] ? DATA_W'(-qin[i]) : DATA_W'(qin[i]);
				qneg_s1[i] <= qin[i][DATA_W-1];
			end
			vec_s1 <= {vec_z, vec_y, vec_x};

			for (int i = 0; i < 4; i++) begin
				sq_s2[i] <= 64'(qm_s1[i]) * 64'(qm_s1[i]);
				qm_s2[i] <= qm_s1[i];
				qm_s3[i] <= qm_s2[i];
				qm_s4[i] <= qm_s3[i];
				qm_s5[i] <= qm_s4[i];
			end
			lim_s2  <= 64'(mm1) * 64'(mm1);
			qneg_s2 <= qneg_s1;
			vec_s2  <= vec_s1;

			sum01_s3 <= 65'(sq_s2[0]) + 65'(sq_s2[1]);
			sum23_s3 <= 65'(sq_s2[2]) + 65'(sq_s2[3]);
			max01_s3 <= (qm_s2[0] > qm_s2[1]) ? qm_s2[0] : qm_s2[1];
			max23_s3 <= (qm_s2[2] > qm_s2[3]) ? qm_s2[2] : qm_s2[3];
			lim_s3   <= lim_s2;
			qneg_s3  <= qneg_s2;
			vec_s3   <= vec_s2;

			ssum_s4 <= 66'(sum01_s3) + 66'(sum23_s3);
			amax_s4 <= (max01_s3 > max23_s3) ? max01_s3 : max23_s3;
			lim_s4  <= lim_s3;
			qneg_s4 <= qneg_s3;
			vec_s4  <= vec_s3;

			rej_s5  <= ssum_s4 < 66'(lim_s4);
			shr_s5  <= amax_s4 > HALF_RANGE;
			shl_s5  <= shl_c;
			qneg_s5 <= qneg_s4;
			vec_s5  <= vec_s4;

			for (int i = 0; i < 4; i++) begin
				qn_s6[i] <= shr_s5 ? NORM_W'(qm_s5[i] >> 1) : NORM_W'(qm_s5[i] << shl_s5);
			end
			rej_s6  <= rej_s5;
			qneg_s6 <= qneg_s5;
			vec_s6  <= vec_s5;

			for (int i = 0; i < 4; i++) begin
				sq2_s7[i] <= 62'(qn_s6[i]) * 62'(qn_s6[i]);
			end
			qn_s7   <= qn_s6;
			rej_s7  <= rej_s6;
			qneg_s7 <= qneg_s6;
			vec_s7  <= vec_s6;

			p01_s8  <= 63'(sq2_s7[0]) + 63'(sq2_s7[1]);
			p23_s8  <= 63'(sq2_s7[2]) + 63'(sq2_s7[3]);
			qn_s8   <= qn_s7;
			rej_s8  <= rej_s7;
			qneg_s8 <= qneg_s7;
			vec_s8  <= vec_s7;

			s2_s9   <= p01_s8 + p23_s8;
			qn_s9   <= qn_s8;
			rej_s9  <= rej_s8;
			qneg_s9 <= qneg_s8;
			vec_s9  <= vec_s8;
		end
	end

	// Square root of the scaled sum of squares.
	logic [ROOT_W-1:0] root;

	qvr_isqrt u_isqrt (
		.clk      (clk),
		.adv      (adv),
		.radicand (s2_s9),
		.root     (root)
	);

	// Side data travels alongside the square root and the dividers.
	side_t  side_s9;
	side_t  side_d [LAT];
	logic   vld_d  [LAT];
	norm4_t qn_d   [ISQRT_STAGES];

	assign side_s9 = '{reject: rej_s9, qneg: qneg_s9, vec: vec_s9};

	// Stage after the root: dividend with half the divisor added for rounding.
	logic [NUM_W-1:0]  num_s10 [4];
	logic [ROOT_W-1:0] den_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s9;
			qn_d[0]   <= qn_s9;
			for (int k = 1; k < LAT; k++) begin
				side_d[k] <= side_d[k-1];
			end
			for (int k = 1; k < ISQRT_STAGES; k++) begin
				qn_d[k] <= qn_d[k-1];
			end
			for (int i = 0; i < 4; i++) begin
				num_s10[i] <= (NUM_W'(qn_d[ISQRT_STAGES-1][i]) << UNIT_FRAC)
					+ NUM_W'(root >> 1);
			end
			den_s10 <= root;
		end
	end

	logic [QUO_W-1:0] mag [4];

	for (genvar i = 0; i < 4; i++) begin : g_div
		qvr_div u_div (
			.clk (clk),
			.adv (adv),
			.num (num_s10[i]),
			.den (den_s10),
			.quo (mag[i])
		);
	end

	// Stages 11 to 16: signed unit quaternion, the two cross products, rounding.
	word_t              u_s11 [4], u_s12 [4], u_s13 [4];
	side_t              side_s11, side_s12, side_s13, side_s14, side_s15, side_s16;
	logic               vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic signed [63:0] p_s12 [6];
	logic signed [63:0] c_sum [3];
	logic signed [T_W-1:0] t_s13 [3];
	logic signed [63:0] pa_s14 [3], pb_s14 [3], pc_s14 [3], vs_s14 [3];
	logic signed [63:0] r1_s15 [3], r2_s15 [3];
	logic signed [63:0] rr [3];
	logic signed [RES_W-1:0] res_s16 [3];

	assign c_sum[0] = p_s12[0] - p_s12[1] + $signed(T_RND);
	assign c_sum[1] = p_s12[2] - p_s12[3] + $signed(T_RND);
	assign c_sum[2] = p_s12[4] - p_s12[5] + $signed(T_RND);

	for (genvar i = 0; i < 3; i++) begin : g_round
		assign rr[i] = r1_s15[i] + r2_s15[i] + $signed(R_RND);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				u_s11[i] <= side_d[LAT-1].qneg[i] ? -DATA_W'(mag[i]) : DATA_W'(mag[i]);
				u_s12[i] <= u_s11[i];
				u_s13[i] <= u_s12[i];
			end
			side_s11 <= side_d[LAT-1];

			// First cross product terms: unit vector part times the input.
			p_s12[0] <= 64'(u_s11[2]) * 64'($signed(side_s11.vec[2]));
			p_s12[1] <= 64'(u_s11[3]) * 64'($signed(side_s11.vec[1]));
			p_s12[2] <= 64'(u_s11[3]) * 64'($signed(side_s11.vec[0]));
			p_s12[3] <= 64'(u_s11[1]) * 64'($signed(side_s11.vec[2]));
			p_s12[4] <= 64'(u_s11[1]) * 64'($signed(side_s11.vec[1]));
			p_s12[5] <= 64'(u_s11[2]) * 64'($signed(side_s11.vec[0]));
			side_s12 <= side_s11;

			// t is twice the cross product, rounded back to vector units.
			for (int i = 0; i < 3; i++) begin
				t_s13[i] <= c_sum[i][63:UNIT_FRAC-1];
			end
			side_s13 <= side_s12;

			for (int i = 0; i < 3; i++) begin
				pa_s14[i] <= 64'(u_s13[0]) * 64'(t_s13[i]);
				pb_s14[i] <= 64'(u_s13[1 + (i + 1) % 3]) * 64'(t_s13[(i + 2) % 3]);
				pc_s14[i] <= 64'(u_s13[1 + (i + 2) % 3]) * 64'(t_s13[(i + 1) % 3]);
				vs_s14[i] <= 64'($signed(side_s13.vec[i])) <<< UNIT_FRAC;
			end
			side_s14 <= side_s13;

			for (int i = 0; i < 3; i++) begin
				r1_s15[i] <= vs_s14[i] + pa_s14[i];
				r2_s15[i] <= pb_s14[i] - pc_s14[i];
			end
			side_s15 <= side_s14;

			for (int i = 0; i < 3; i++) begin
				res_s16[i] <= rr[i][63:UNIT_FRAC];
			end
			side_s16 <= side_s15;
		end
	end

	// Output stage: saturation and the degenerate case.
	word_t      sat_val [3];
	logic [2:0] sat_hit;
	logic       rej_out_q;

	for (genvar i = 0; i < 3; i++) begin : g_sat
		always_comb begin
			sat_hit[i] = 1'b0;
			sat_val[i] = res_s16[i][DATA_W-1:0];
			if (!res_s16[i][RES_W-1] && (|res_s16[i][RES_W-2:DATA_W-1])) begin
				sat_hit[i] = 1'b1;
				sat_val[i] = SAT_MAX;
			end else if (res_s16[i][RES_W-1] && !(&res_s16[i][RES_W-2:DATA_W-1])) begin
				sat_hit[i] = 1'b1;
				sat_val[i] = SAT_MIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rej_out_q <= side_s16.reject;
			if (side_s16.reject) begin
				out_x   <= '0;
				out_y   <= '0;
				out_z   <= '0;
				invalid <= 1'b1;
			end else begin
				out_x   <= sat_val[0];
				out_y   <= sat_val[1];
				out_z   <= sat_val[2];
				invalid <= |sat_hit;
			end
		end
	end

	// Valid bits for every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			for (int k = 0; k < LAT; k++) begin
				vld_d[k] <= 1'b0;
			end
			vld_s11   <= 1'b0;
			vld_s12   <= 1'b0;
			vld_s13   <= 1'b0;
			vld_s14   <= 1'b0;
			vld_s15   <= 1'b0;
			vld_s16   <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			vld_s7   <= vld_s6;
			vld_s8   <= vld_s7;
			vld_s9   <= vld_s8;
			vld_d[0] <= vld_s9;
			for (int k = 1; k < LAT; k++) begin
				vld_d[k] <= vld_d[k-1];
			end
			vld_s11   <= vld_d[LAT-1];
			vld_s12   <= vld_s11;
			vld_s13   <= vld_s12;
			vld_s14   <= vld_s13;
			vld_s15   <= vld_s14;
			vld_s16   <= vld_s15;
			out_valid <= vld_s16;
		end
	end

	// An empty output register never blocks the input side.
	`QVR_ASSERT_IMPL(a_empty_ready, clk, arst_n, !out_valid, in_ready)
	// A stalled output freezes the stage before the output register.
	`QVR_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, $stable(vld_s16))
	// A finished item reaches the output register when the pipeline moves.
	`QVR_ASSERT_NEXT(a_deliver, clk, arst_n, adv && vld_s16, out_valid)
	// A rejected quaternion gives zero outputs with the flag raised.
	`QVR_ASSERT_IMPL(a_reject_zero, clk, arst_n, out_valid && rej_out_q,
		invalid && out_x == '0 && out_y == '0 && out_z == '0)

endmodule
